FILE: sv/mlet_pkg.sv
package mlet_pkg;

  localparam int X_MAX_DEF     = 65536;
  localparam int COEF_BITS_DEF = 32;
  localparam int IN_COEF_W     = 32;
  localparam int QX_W          = 17;
  localparam int VAL_W         = 49;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic mul;
    logic ev;
    logic put;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic query;
    logic stop;
    logic out_free;
  } status_t;

endpackage

FILE: sv/mlet_req_if.sv
interface mlet_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  action;
  logic signed [mlet_pkg::IN_COEF_W-1:0] slope;
  logic signed [mlet_pkg::IN_COEF_W-1:0] intercept;
  logic        [mlet_pkg::QX_W-1:0]      query_x;

  modport source (output valid, action, slope, intercept, query_x, input ready);
  modport sink   (input valid, action, slope, intercept, query_x, output ready);
endinterface

FILE: sv/mlet_rsp_if.sv
interface mlet_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [mlet_pkg::VAL_W-1:0] max_value;

  modport source (output valid, max_value, input ready);
  modport sink   (input valid, max_value, output ready);
endinterface

FILE: sv/max_line_envelope_tree_unit.sv
// Each request: an accept step, then per tree level a read, a multiply and an
// evaluate/write step, over up to clog2(X_MAX)+1 levels; a query then waits until
// the output register is free and loads it.
// One request at a time, bounded by the node memory walk.
// Reset (rst, synchronous, active high) starts a clearing pass over all 2**(clog2(X_MAX)+1)
// node words (131072 by default), during which no request is taken.
module max_line_envelope_tree_unit #(
  parameter int X_MAX     = mlet_pkg::X_MAX_DEF,
  parameter int COEF_BITS = mlet_pkg::COEF_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  mlet_req_if.sink     req,
  mlet_rsp_if.source   rsp
);
  import mlet_pkg::*;

  cmd_t    cmd;
  status_t st;

  mlet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mlet_dp #(
    .X_MAX     (X_MAX),
    .COEF_BITS (COEF_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .action    (req.action),
    .slope     (req.slope),
    .intercept (req.intercept),
    .query_x   (req.query_x),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .max_value (rsp.max_value)
  );

endmodule

FILE: sv/mlet_ctrl.sv
module mlet_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mlet_pkg::status_t st,
  output mlet_pkg::cmd_t    cmd
);
  import mlet_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.ev = 1'b1;
        if (st.stop) begin
          state_next = st.query ? ST_DONE : ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE: begin
        // result waits here until the output register is free
        if (st.out_free) begin
          cmd.put    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

FILE: sv/mlet_dp.sv
module mlet_dp #(
  parameter int X_MAX     = mlet_pkg::X_MAX_DEF,
  parameter int COEF_BITS = mlet_pkg::COEF_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mlet_pkg::cmd_t                        cmd,
  output mlet_pkg::status_t                     st,
  input  logic                                  action,
  input  logic signed [mlet_pkg::IN_COEF_W-1:0] slope,
  input  logic signed [mlet_pkg::IN_COEF_W-1:0] intercept,
  input  logic        [mlet_pkg::QX_W-1:0]      query_x,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mlet_pkg::VAL_W-1:0]     max_value
);
  import mlet_pkg::*;

  localparam int COEF_W = (COEF_BITS < 32) ? COEF_BITS : 32;
  localparam int XW     = $clog2(X_MAX + 1);
  localparam int IW     = $clog2(X_MAX) + 1;
  localparam int NODES  = 2 ** IW;
  localparam int PW     = COEF_W + XW + 1;
  localparam int EW     = (PW > 51) ? PW : 51;
  localparam int MW     = 1 + 2 * COEF_W;
  localparam logic signed [EW-1:0] LIM_P = EW'(64'sd281474976710656);
  localparam logic signed [EW-1:0] LIM_N = -LIM_P;

  // node word: valid, slope, intercept
  logic [MW-1:0] mem [NODES];
  logic [MW-1:0] rdata;
  logic [MW-1:0] wdata;
  logic [IW-1:0] waddr;
  logic          we;

  logic [IW-1:0] idx;
  logic [IW-1:0] clr_addr;
  logic [XW-1:0] lo, hi, xq, mid, pos, dpos, xin;
  logic [XW:0]   lohi;
  logic signed [XW:0] dsig;
  logic          is_query;
  logic          any_line;

  logic signed [COEF_W-1:0] ns, nc, os, oc;
  logic signed [PW-1:0]     pn, po;
  logic signed [VAL_W-1:0]  best, vn, vo, vcur;
  logic r_valid, leaf, stop, swap, lt, go_right;

  function automatic logic signed [VAL_W-1:0] sat_val(
    input logic signed [PW-1:0]     p,
    input logic signed [COEF_W-1:0] c
  );
    logic signed [EW-1:0] pe;
    logic signed [EW-1:0] s;
    pe = EW'(p);
    s  = pe + EW'(c);
    if (pe > LIM_P) sat_val = VAL_MAX;
    else if (pe < LIM_N) sat_val = VAL_MIN;
    else if (s > EW'(VAL_MAX)) sat_val = VAL_MAX;
    else if (s < EW'(VAL_MIN)) sat_val = VAL_MIN;
    else sat_val = s[VAL_W-1:0];
  endfunction

  assign lohi = {1'b0, lo} + {1'b0, hi};
  assign mid  = lohi[XW:1];
  assign pos  = is_query ? xq : mid;
  assign dpos = pos - XW'(1);
  assign dsig = signed'({1'b0, dpos});

  assign r_valid = rdata[MW-1];
  assign os      = rdata[2*COEF_W-1:COEF_W];
  assign oc      = rdata[COEF_W-1:0];

  assign vn   = sat_val(pn, nc);
  assign vo   = sat_val(po, oc);
  assign vcur = r_valid ? vo : '0;
  assign leaf = (lo == hi);
  assign stop = leaf || (!is_query && (!r_valid || os == ns));
  // midpoint tie keeps the new line
  assign swap = (vo <= vn);
  assign lt   = (os < ns);
  assign go_right = is_query ? (xq > mid) : (swap ^ lt);

  assign xin = (query_x == '0) ? XW'(1) :
               (32'(query_x) > 32'(X_MAX)) ? XW'(X_MAX) : XW'(query_x);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {1'b1, ns, nc};
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (cmd.ev && !is_query) begin
      if (leaf) begin
        we = (vn > vcur);
      end else if (!r_valid) begin
        we = 1'b1;
      end else if (os == ns) begin
        we    = (nc > oc);
        wdata = {1'b1, os, nc};
      end else begin
        we = swap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      any_line  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) clr_addr <= clr_addr + IW'(1);
      if (cmd.load && action == ACT_INSERT) any_line <= 1'b1;
      if (cmd.put) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_query <= (action == ACT_QUERY);
      ns       <= slope[COEF_W-1:0];
      nc       <= intercept[COEF_W-1:0];
      xq       <= xin;
      lo       <= XW'(1);
      hi       <= XW'(X_MAX);
      idx      <= IW'(1);
      best     <= VAL_MIN;
    end
    if (cmd.mul) begin
      pn <= PW'(ns) * PW'(dsig);
      po <= PW'(os) * PW'(dsig);
    end
    if (cmd.ev) begin
      if (is_query && vcur > best) best <= vcur;
      if (!stop) begin
        idx <= {idx[IW-2:0], go_right};
        if (go_right) lo <= mid + XW'(1);
        else hi <= mid;
        // displaced line carries on down
        if (!is_query && swap) begin
          ns <= os;
          nc <= oc;
        end
      end
    end
    if (cmd.put) max_value <= any_line ? best : '0;
  end

  assign st.clr_last = (clr_addr == {IW{1'b1}});
  assign st.query    = is_query;
  assign st.stop     = stop;
  assign st.out_free = !out_valid || out_ready;

endmodule

FILE: sv/mlet_chk.sv
module mlet_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              req_action,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [mlet_pkg::VAL_W-1:0] rsp_max_value
);
  import mlet_pkg::*;

  // queries taken but not yet answered
  logic [1:0] qcnt;
  logic       inc, dec;

  assign inc = req_valid && req_ready && (req_action == ACT_QUERY);
  assign dec = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt <= '0;
    end else if (inc && !dec) begin
      qcnt <= qcnt + 2'd1;
    end else if (dec && !inc) begin
      qcnt <= qcnt - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_max_value))
    else $error("result dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> qcnt != 2'd0)
    else $error("result without an outstanding query");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    qcnt != 2'd3)
    else $error("too many queries outstanding");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

endmodule

bind max_line_envelope_tree_unit mlet_chk u_mlet_chk (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_action    (req.action),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_max_value (rsp.max_value)
);
